[rtl/gbn_pkg.sv]
// gbn_pkg: types and constants shared by the Go-Back-N sender window.
// No dependencies; used by every module of the block.
package gbn_pkg;

  localparam int SEQ_W = 16;          // sequence number and frame count width
  localparam int CNT_W = SEQ_W + 1;   // base / next counters

  // input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_ACK   = 2'd2;

  // classified operations handed from front to back
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_RESEND = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // configuration register indexes
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [1:0]       command;
    logic [SEQ_W-1:0] frame_count;
    logic [SEQ_W-1:0] ack_seq;
  } gbn_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] frame_seq;
    logic [CNT_W-1:0] window_base;
    logic             done_res;
    logic             last;
  } gbn_result_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [SEQ_W-1:0] frame_count;
    logic [SEQ_W-1:0] ack_seq;
  } gbn_op_t;

endpackage

[rtl/go_back_n_sender_window.sv]
// Go-Back-N sender window controller. An accepted input word passes the front
// register, the queue, the pop and the decode before its first result word; an
// ack that slides the window first walks the slide. The back end takes one item
// at a time and gives 1 to WINDOW_MAX+1 result words per item.
// Synchronous reset: base and next at 1, idle, window 8, timeout 100.
module go_back_n_sender_window #(
  parameter int WINDOW_MAX = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  gbn_pkg::gbn_item_t        item,
  output logic                      res_valid,
  input  logic                      res_stall,
  output gbn_pkg::gbn_result_t      res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [gbn_pkg::SEQ_W-1:0] cfg_data
);

  logic [3:0]                window_size;
  logic [gbn_pkg::SEQ_W-1:0] timeout_ticks;

  logic             f_valid;
  logic             q_full;
  gbn_pkg::gbn_op_t f_word;
  logic             q_valid;
  logic             q_pop;
  gbn_pkg::gbn_op_t q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= 4'd8;
      timeout_ticks <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbn_pkg::REG_WINDOW:  window_size   <= cfg_data[3:0];
        gbn_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  gbn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .op_valid   (f_valid),
    .op_full    (q_full),
    .op_word    (f_word)
  );

  gbn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .full      (q_full),
    .push_word (f_word),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_word  (q_word)
  );

  gbn_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .window_size   (window_size),
    .timeout_ticks (timeout_ticks),
    .op_valid      (q_valid),
    .op_pop        (q_pop),
    .op_word       (q_word),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res)
  );

endmodule

[rtl/gbn_front.sv]
// gbn_front: accepts input words, decodes the command and holds one
// classified word for the queue. Depends on gbn_pkg.
module gbn_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  gbn_pkg::gbn_item_t item,
  output logic              op_valid,
  input  logic              op_full,
  output gbn_pkg::gbn_op_t  op_word
);

  logic             hold_valid;
  gbn_pkg::gbn_op_t hold;
  logic [1:0]       op_code;

  always_comb begin
    unique case (item.command)
      gbn_pkg::CMD_START: op_code = gbn_pkg::OP_START;
      gbn_pkg::CMD_TICK:  op_code = gbn_pkg::OP_TICK;
      gbn_pkg::CMD_ACK:   op_code = gbn_pkg::OP_ACK;
      default:            op_code = gbn_pkg::OP_NOP;
    endcase
  end

  assign item_stall = hold_valid & op_full;
  assign op_valid   = hold_valid;
  assign op_word    = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold.op          <= op_code;
      hold.frame_count <= item.frame_count;
      hold.ack_seq     <= item.ack_seq;
    end
  end

endmodule

[rtl/gbn_queue.sv]
// gbn_queue: two-entry queue of classified words between front and back.
// Depends on gbn_pkg.
module gbn_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  gbn_pkg::gbn_op_t push_word,
  output logic             pop_valid,
  input  logic             pop,
  output gbn_pkg::gbn_op_t pop_word
);

  gbn_pkg::gbn_op_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;
  assign pop_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

[rtl/gbn_back.sv]
// gbn_back: window state and sequencer. Executes one classified word at a
// time, walks sends, resend bursts and window slides. Depends on gbn_pkg.
module gbn_back #(
  parameter int WINDOW_MAX = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [3:0]                window_size,
  input  logic [gbn_pkg::SEQ_W-1:0] timeout_ticks,
  input  logic                      op_valid,
  output logic                      op_pop,
  input  gbn_pkg::gbn_op_t          op_word,
  output logic                      res_valid,
  input  logic                      res_stall,
  output gbn_pkg::gbn_result_t      res
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW    = gbn_pkg::CNT_W;
  localparam int SW    = gbn_pkg::SEQ_W;
  localparam logic [CW-1:0] WMAX = CW'(WINDOW_MAX);
  localparam logic [SW-1:0] TMAX = '1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SEND   = 3'd2;
  localparam logic [2:0] S_RESEND = 3'd3;
  localparam logic [2:0] S_SLIDE  = 3'd4;
  localparam logic [2:0] S_STATUS = 3'd5;

  logic [2:0]            state;
  gbn_pkg::gbn_op_t      work;
  logic [CW-1:0]         base;
  logic [CW-1:0]         nxt;
  logic [SW-1:0]         total;
  logic [WINDOW_MAX-1:0] marks;    // marks[i]: frame base+i acknowledged
  logic                  running;
  logic [SW-1:0]         tcount;
  logic [CW-1:0]         rs;       // resend walk
  logic                  expire;

  logic                  out_free;
  logic                  res_load;
  logic                  done_now;
  logic [CW-1:0]         win;
  logic                  send;
  logic                  start_timer;
  logic                  run1;
  logic [SW-1:0]         cnt0;
  logic [SW-1:0]         cnt1;
  logic                  expire1;
  logic [CW-1:0]         ack17;
  logic [CW-1:0]         ack_off;
  logic                  ack_in;
  logic [CW-1:0]         rs_inc;

  assign out_free = ~res_valid | ~res_stall;
  assign res_load = out_free & ((state == S_SEND) | (state == S_RESEND) |
                                (state == S_STATUS));
  assign done_now = (base > {1'b0, total});
  assign op_pop   = (state == S_IDLE) & op_valid;
  assign rs_inc   = rs + CW'(1);

  // tick decision: send check, then timer update
  always_comb begin
    if (window_size == 4'd0) begin
      win = CW'(1);
    end else if ({{(CW-4){1'b0}}, window_size} > WMAX) begin
      win = WMAX;
    end else begin
      win = {{(CW-4){1'b0}}, window_size};
    end
    send        = (nxt < base + win) && (nxt <= {1'b0, total});
    start_timer = send && (base == nxt);
    run1        = running | start_timer;
    cnt0        = start_timer ? '0 : tcount;
    cnt1        = (cnt0 == TMAX) ? cnt0 : cnt0 + SW'(1);
    expire1     = run1 && (cnt1 > timeout_ticks);
  end

  always_comb begin
    ack17   = {1'b0, work.ack_seq};
    ack_off = ack17 - base;
    ack_in  = (ack17 >= base) && (ack17 < nxt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= CW'(1);
      nxt       <= CW'(1);
      total     <= '0;
      marks     <= '0;
      running   <= 1'b0;
      tcount    <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_load | (res_valid & res_stall);
      unique case (state)
        S_IDLE: begin
          if (op_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          case (work.op)
            gbn_pkg::OP_START: begin
              total   <= work.frame_count;
              base    <= CW'(1);
              nxt     <= CW'(1);
              marks   <= '0;
              running <= 1'b0;
              tcount  <= '0;
              state   <= S_STATUS;
            end
            gbn_pkg::OP_TICK: begin
              if (send) nxt <= nxt + CW'(1);
              if (run1) begin
                running <= 1'b1;
                tcount  <= expire1 ? '0 : cnt1;
              end
              expire <= expire1;
              rs     <= base;
              if (send) begin
                state <= S_SEND;
              end else if (expire1) begin
                state <= S_RESEND;
              end else begin
                state <= S_STATUS;
              end
            end
            gbn_pkg::OP_ACK: begin
              if (ack_in) begin
                marks[ack_off[IDX_W-1:0]] <= 1'b1;
                if (ack17 == base) begin
                  state <= S_SLIDE;
                end else begin
                  running <= 1'b1;
                  tcount  <= '0;
                  state   <= S_STATUS;
                end
              end else begin
                state <= S_STATUS;
              end
            end
            default: state <= S_STATUS;
          endcase
        end
        S_SEND: begin
          if (out_free) begin
            state <= expire ? S_RESEND : S_IDLE;
          end
        end
        S_RESEND: begin
          if (out_free) begin
            rs <= rs_inc;
            if (rs_inc >= nxt) state <= S_IDLE;
          end
        end
        S_SLIDE: begin
          // one frame per cycle past acknowledged frames
          if (marks[0] && base < nxt) begin
            marks <= marks >> 1;
            base  <= base + CW'(1);
          end else begin
            running <= (base != nxt);
            tcount  <= '0;
            state   <= S_STATUS;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (op_pop) work <= op_word;
    if (out_free) begin
      res.window_base <= base;
      res.done_res    <= done_now;
      case (state)
        S_SEND: begin
          res.kind      <= gbn_pkg::KIND_SEND;
          res.frame_seq <= SW'(nxt - CW'(1));
          res.last      <= ~expire;
        end
        S_RESEND: begin
          res.kind      <= gbn_pkg::KIND_RESEND;
          res.frame_seq <= rs[SW-1:0];
          res.last      <= (rs_inc >= nxt);
        end
        default: begin
          res.kind      <= gbn_pkg::KIND_STATUS;
          res.frame_seq <= '0;
          res.last      <= 1'b1;
        end
      endcase
    end
  end

endmodule

[tb/tb_go_back_n_sender_window.sv]
`timescale 1ns / 1ps
// Self-checking testbench for go_back_n_sender_window: a window tracker class predicts
// each result word from the accepted commands and matches the output stream in order.
// Depends on gbn_pkg and the go_back_n_sender_window RTL.
module tb_go_back_n_sender_window;

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int CW = gbn_pkg::CNT_W;
  localparam int WMAX = 8;
  localparam int MAX_BURST = WMAX + 1;
  localparam logic [1:0] CMD_BOGUS = 2'd3;
  localparam int SETTLE = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 68;
  localparam int NUM_PHASES = 6;

  class window_tracker;
    logic [3:0]           win_reg;
    logic [SW-1:0]        tmo_reg;
    logic [CW-1:0]        base;
    logic [CW-1:0]        nxt;
    logic [SW-1:0]        total;
    bit                   acked [WMAX];
    bit                   timer_on;
    logic [SW-1:0]        timer;
    gbn_pkg::gbn_result_t due [$];
    int                   errors = 0;

    function void power_on();
      win_reg  = 4'd8;
      tmo_reg  = 16'd100;
      base     = CW'(1);
      nxt      = CW'(1);
      total    = '0;
      foreach (acked[i]) acked[i] = 1'b0;
      timer_on = 1'b0;
      timer    = '0;
    endfunction

    function void set_reg(logic idx, logic [SW-1:0] d);
      if (idx == gbn_pkg::REG_WINDOW) begin
        win_reg = d[3:0];
      end else begin
        tmo_reg = d;
      end
    endfunction

    function int span();
      if (win_reg == 0) return 1;
      if (win_reg > WMAX) return WMAX;
      return int'(win_reg);
    endfunction

    function void take_command(gbn_pkg::gbn_item_t it);
      gbn_pkg::gbn_result_t burst [$];
      gbn_pkg::gbn_result_t r;
      logic [CW-1:0]        s;
      logic [CW-1:0]        a;
      case (it.command)
        gbn_pkg::CMD_START: begin
          total = it.frame_count;
          base = CW'(1);
          nxt = CW'(1);
          foreach (acked[i]) acked[i] = 1'b0;
          timer_on = 1'b0;
          timer = '0;
        end
        gbn_pkg::CMD_TICK: begin
          if (nxt < base + span() && nxt <= total) begin
            r = '0;
            r.kind = gbn_pkg::KIND_SEND;
            r.frame_seq = nxt[SW-1:0];
            burst.push_back(r);
            acked[nxt % WMAX] = 1'b0;
            if (base == nxt) begin
              timer_on = 1'b1;
              timer = '0;
            end
            nxt = nxt + 1'b1;
          end
          if (timer_on) begin
            if (timer != '1) timer = timer + 1'b1;
            if (timer > tmo_reg) begin
              timer = '0;
              for (s = base; s < nxt && burst.size() < MAX_BURST; s++) begin
                r = '0;
                r.kind = gbn_pkg::KIND_RESEND;
                r.frame_seq = s[SW-1:0];
                burst.push_back(r);
              end
            end
          end
        end
        gbn_pkg::CMD_ACK: begin
          a = {1'b0, it.ack_seq};
          if (a >= base && a < nxt) begin
            acked[a % WMAX] = 1'b1;
            if (a == base) begin
              while (base < nxt && acked[base % WMAX]) begin
                acked[base % WMAX] = 1'b0;
                base = base + 1'b1;
              end
            end
            // timer restarts while frames remain outstanding
            timer_on = (base != nxt);
            timer = '0;
          end
        end
        default: ;
      endcase
      if (burst.size() == 0) begin
        r = '0;
        r.kind = gbn_pkg::KIND_STATUS;
        burst.push_back(r);
      end
      foreach (burst[i]) begin
        burst[i].window_base = base;
        burst[i].done_res = (base > total);
        burst[i].last = (i == burst.size() - 1);
        due.push_back(burst[i]);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t ERROR: %s", $time, msg);
    endtask

    task check_result(gbn_pkg::gbn_result_t got);
      gbn_pkg::gbn_result_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", got));
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.frame_seq !== want.frame_seq)
        report_mismatch($sformatf("frame_seq %0d, want %0d", got.frame_seq, want.frame_seq));
      if (got.window_base !== want.window_base)
        report_mismatch($sformatf("window_base %0d, want %0d",
                                  got.window_base, want.window_base));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  gbn_pkg::gbn_item_t   item;
  logic                 res_valid;
  logic                 res_stall;
  gbn_pkg::gbn_result_t res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [SW-1:0]        cfg_data;

  window_tracker tracker;
  bit            quiet_tail;
  bit            hold_request;
  bit            tx_calm;
  int            idle_cycles;

  go_back_n_sender_window #(
    .WINDOW_MAX(WMAX)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst !== 1'b1 && res_valid && !res_stall) tracker.check_result(res);
  end

  // counts cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (rst !== 1'b0) begin
      idle_cycles = 0;
    end else if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("go_back_n_sender_window verification failed");
        $finish;
      end
    end
  end

  // result side: short random stall bursts, calm stretches, two long hold-offs
  initial begin
    bit calm;
    calm = 1'b0;
    res_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        res_stall <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) calm = !calm;
    end
  end

  function automatic gbn_pkg::gbn_item_t make_item(logic [1:0] c, logic [SW-1:0] fc,
                                                   logic [SW-1:0] ak);
    gbn_pkg::gbn_item_t it;
    it.command = c;
    it.frame_count = fc;
    it.ack_seq = ak;
    return it;
  endfunction

  function automatic gbn_pkg::gbn_item_t random_item();
    gbn_pkg::gbn_item_t it;
    int                 p;
    int                 lo;
    int                 hi;
    it = make_item(gbn_pkg::CMD_TICK, SW'($urandom), SW'($urandom));
    p = $urandom_range(0, 99);
    // a finished transfer often gets a fresh start
    if (tracker.base > tracker.total && p < 40) p = 0;
    if (p < 5) begin
      it.command = gbn_pkg::CMD_START;
      if ($urandom_range(0, 15) != 0) it.frame_count = SW'($urandom_range(1, 24));
    end else if (p < 50) begin
      it.command = gbn_pkg::CMD_TICK;
    end else if (p < 85) begin
      if (tracker.nxt > tracker.base) begin
        lo = int'(tracker.base);
        hi = int'(tracker.nxt) - 1;
        it.command = gbn_pkg::CMD_ACK;
        it.ack_seq = SW'($urandom_range(0, 1) ? lo : $urandom_range(lo, hi));
      end
    end else if (p < 95) begin
      it.command = gbn_pkg::CMD_ACK;
      case ($urandom_range(0, 2))
        0: it.ack_seq = tracker.nxt[SW-1:0];
        1: it.ack_seq = tracker.base[SW-1:0] - 1'b1;
        default: ;
      endcase
    end else begin
      it.command = CMD_BOGUS;
    end
    return it;
  endfunction

  task automatic push_item(gbn_pkg::gbn_item_t it);
    if (!quiet_tail && !tx_calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    tracker.take_command(it);
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_config(logic [3:0] win, logic [SW-1:0] tmo);
    logic [SW-1:0] wd;
    wd = {12'($urandom_range(0, 4095)), win};
    cfg_valid <= 1'b1;
    cfg_index <= gbn_pkg::REG_WINDOW;
    cfg_data <= wd;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(gbn_pkg::REG_WINDOW, wd);
    cfg_index <= gbn_pkg::REG_TIMEOUT;
    cfg_data <= tmo;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(gbn_pkg::REG_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int win_set [NUM_PHASES];
    int tmo_set [NUM_PHASES];
    win_set = '{1, 15, 0, 4, 8, 0};
    tmo_set = '{0, 2, 65535, 5, 1, 0};
    tracker = new();
    tracker.power_on();
    quiet_tail = 1'b0;
    hold_request = 1'b0;
    tx_calm = 1'b0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= gbn_pkg::REG_WINDOW;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // idle block before any transfer
    push_item(make_item(gbn_pkg::CMD_TICK, '1, '1));
    push_item(make_item(gbn_pkg::CMD_ACK, '0, '0));
    push_item(make_item(gbn_pkg::CMD_ACK, '0, '1));
    push_item(make_item(CMD_BOGUS, '1, '1));
    push_item(make_item(gbn_pkg::CMD_START, '0, '1));
    push_item(make_item(gbn_pkg::CMD_TICK, '0, '0));
    // full window, then one tick blocked by it
    push_item(make_item(gbn_pkg::CMD_START, '1, '0));
    repeat (9) push_item(make_item(gbn_pkg::CMD_TICK, SW'($urandom), SW'($urandom)));
    // out-of-order ack, slides, and acks outside the window
    push_item(make_item(gbn_pkg::CMD_ACK, '0, 16'd3));
    push_item(make_item(gbn_pkg::CMD_ACK, '0, 16'd1));
    push_item(make_item(gbn_pkg::CMD_ACK, '1, 16'd2));
    push_item(make_item(gbn_pkg::CMD_ACK, '0, 16'd1));
    push_item(make_item(gbn_pkg::CMD_ACK, '0, 16'd12));
    // single-frame transfer to completion
    push_item(make_item(gbn_pkg::CMD_START, 16'd1, '1));
    push_item(make_item(gbn_pkg::CMD_TICK, '0, '0));
    push_item(make_item(gbn_pkg::CMD_ACK, '1, 16'd1));
    push_item(make_item(gbn_pkg::CMD_TICK, '0, '0));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        win_set[ph] = $urandom_range(0, 15);
        tmo_set[ph] = $urandom_range(0, 12);
        quiet_tail = 1'b1;
      end
      load_config(4'(win_set[ph]), SW'(tmo_set[ph]));
      if (ph == 1 || ph == 3) hold_request = 1'b1;
      repeat (PHASE_ITEMS) push_item(random_item());
      drain();
    end

    if (tracker.due.size() != 0)
      tracker.report_mismatch($sformatf("%0d result words never arrived", tracker.due.size()));
    if (tracker.errors == 0) begin
      $display("go_back_n_sender_window verification clean");
    end else begin
      $display("go_back_n_sender_window verification failed");
    end
    $finish;
  end

endmodule
